/* rtl/i2cee_pkg.sv */
// Package for the I2C EEPROM page transfer sequencer.
// Holds opcodes, bus command codes, status codes, phase type and shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package i2cee_pkg;
	localparam int DEF_ADDRESS_BITS = 18;
	localparam int DEF_MAX_PAGE_LOG2 = 6;

	typedef enum logic [1:0] {
		OP_BEGIN_WRITE = 2'd0,
		OP_WRITE_DATA  = 2'd1,
		OP_BEGIN_READ  = 2'd2,
		OP_BUS_STATUS  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		CMD_START_WRITE = 3'd0,
		CMD_START_READ  = 3'd1,
		CMD_SEND        = 3'd2,
		CMD_RECV_ACK    = 3'd3,
		CMD_RECV_NACK   = 3'd4,
		CMD_STOP        = 3'd5,
		CMD_POLL        = 3'd6,
		CMD_STATUS      = 3'd7
	} command_t;

	typedef enum logic [2:0] {
		ST_BUSY       = 3'd0,
		ST_DONE       = 3'd1,
		ST_ADDR_ERROR = 3'd2,
		ST_WR_ERROR   = 3'd3,
		ST_RD_ERROR   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_WR_DATA = 3'd1,
		PH_WR_STOP = 3'd2,
		PH_WR_POLL = 3'd3,
		PH_RD_ADDR = 3'd4,
		PH_RD_DATA = 3'd5,
		PH_RD_NEXT = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		REG_DEVICE_ADDRESS = 3'd0,
		REG_PAGE_SIZE_LOG2 = 3'd1,
		REG_CS_SHIFT       = 3'd2,
		REG_TWO_ADDR       = 3'd3,
		REG_CAPACITY       = 3'd4,
		REG_POLL_LIMIT     = 3'd5
	} reg_index_t;

	localparam int MAX_RESULTS = 5;

	// One bus result beat.
	typedef struct packed {
		logic [2:0] command;
		logic [7:0] bus_byte;
		logic [2:0] status;
		logic       last;
	} result_t;

	// Configuration snapshot handed from the register file.
	typedef struct packed {
		logic [7:0]  device_address;
		logic [2:0]  page_size_log2;
		logic [4:0]  chip_select_shift;
		logic        two_address_bytes;
		logic [18:0] capacity_bytes;
		logic [7:0]  poll_limit;
	} cfg_t;
endpackage
`default_nettype wire

/* rtl/i2c_eeprom_page_transfer_sequencer_core.sv */
// Top level of the I2C EEPROM page transfer sequencer.
// Joins the front step unit and the result queue. Depends on i2cee_pkg.
//
//  channel  | handshake          | beat contents
//  ---------+--------------------+-----------------------------------------
//  request  | push / full        | opcode, address, length, data, bus_ok
//  result   | pop / empty        | command, bus_byte, status, last
//  config   | cfg_we             | cfg_index, cfg_data
//
// The front unit handles each accepted request combinationally; its up to five
// result beats pass burst_s1 into the queue and leave one per cycle on pop.
// A request can be taken every cycle while the 16-entry queue has room for two
// full bursts. Reset clears state and queue; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module i2c_eeprom_page_transfer_sequencer_core #(
	parameter int ADDRESS_BITS = i2cee_pkg::DEF_ADDRESS_BITS,
	parameter int MAX_PAGE_LOG2 = i2cee_pkg::DEF_MAX_PAGE_LOG2
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [2:0]              cfg_index,
	input  wire logic [18:0]             cfg_data,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic [1:0]              opcode,
	input  wire logic [ADDRESS_BITS-1:0] address,
	input  wire logic [15:0]             length,
	input  wire logic [7:0]              data,
	input  wire logic                    bus_ok,
	output logic                         empty,
	input  wire logic                    pop,
	output logic [2:0]                   command,
	output logic [7:0]                   bus_byte,
	output logic [2:0]                   status,
	output logic                         last
);
	import i2cee_pkg::*;

	result_t burst_s1 [MAX_RESULTS];
	logic [2:0] burst_count_s1;
	result_t head;

	i2cee_front #(.ADDRESS_BITS(ADDRESS_BITS), .MAX_PAGE_LOG2(MAX_PAGE_LOG2)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(push && !full), .opcode, .address, .length, .data, .bus_ok,
		.burst_s1, .burst_count_s1
	);

	i2cee_queue u_queue (
		.clk, .arst_n, .burst_s1, .burst_count_s1, .pop, .empty, .full, .head
	);

	assign command = head.command;
	assign bus_byte = head.bus_byte;
	assign status = head.status;
	assign last = head.last;

	// A burst never holds more beats than one item can cause.
	assert property (@(posedge clk) disable iff (!arst_n)
		burst_count_s1 <= 3'(MAX_RESULTS))
		else $error("burst too long");

	// Nothing is queued in the cycle after an idle input with an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !push && !pop) |=> (burst_count_s1 == 3'd0))
		else $error("beat without request");

	// A done or error status always ends its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_BUSY) |-> last)
		else $error("final status not last");
endmodule
`default_nettype wire

/* rtl/i2cee_front.sv */
// Front part: registers the configuration, keeps the request state and turns each
// input item into a burst of up to five result beats. Depends on i2cee_pkg.
`timescale 1ns / 1ps
`default_nettype none
module i2cee_front #(
	parameter int ADDRESS_BITS = i2cee_pkg::DEF_ADDRESS_BITS,
	parameter int MAX_PAGE_LOG2 = i2cee_pkg::DEF_MAX_PAGE_LOG2
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [2:0]               cfg_index,
	input  wire logic [18:0]              cfg_data,
	input  wire logic                     in_valid,
	input  wire logic [1:0]               opcode,
	input  wire logic [ADDRESS_BITS-1:0]  address,
	input  wire logic [15:0]              length,
	input  wire logic [7:0]               data,
	input  wire logic                     bus_ok,
	output i2cee_pkg::result_t            burst_s1 [i2cee_pkg::MAX_RESULTS],
	output logic [2:0]                    burst_count_s1
);
	import i2cee_pkg::*;

	localparam int PW = MAX_PAGE_LOG2 + 1;
	localparam int AW1 = (ADDRESS_BITS > 16 ? ADDRESS_BITS : 16) + 1;

	cfg_t cfg_q;
	phase_t phase_q, phase_d;
	logic [ADDRESS_BITS-1:0] cur_q, cur_d;
	logic [15:0] rem_q, rem_d;
	logic [PW-1:0] pleft_q, pleft_d;
	logic [7:0] poll_q, poll_d;

	result_t res [MAX_RESULTS];
	logic [2:0] cnt;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= 8'd160;
			cfg_q.page_size_log2 <= 3'd3;
			cfg_q.chip_select_shift <= 5'd8;
			cfg_q.two_address_bytes <= 1'b0;
			cfg_q.capacity_bytes <= 19'd256;
			cfg_q.poll_limit <= 8'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data[7:0];
				REG_PAGE_SIZE_LOG2: cfg_q.page_size_log2 <= cfg_data[2:0];
				REG_CS_SHIFT: cfg_q.chip_select_shift <= cfg_data[4:0];
				REG_TWO_ADDR: cfg_q.two_address_bytes <= cfg_data[0];
				REG_CAPACITY: cfg_q.capacity_bytes <= cfg_data;
				REG_POLL_LIMIT: cfg_q.poll_limit <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Derived values of the current segment.
	logic [3:0] lg;
	logic [PW:0] page_sz, room;
	logic [PW-1:0] seg_len;
	logic [7:0] ctrl_cur, ctrl_new;
	logic [AW1-1:0] range_sum;
	logic range_bad;
	logic [ADDRESS_BITS-1:0] base_addr;
	logic [15:0] base_rem;

	function automatic logic [7:0] ctrl_of(input logic [ADDRESS_BITS-1:0] a,
		input logic [7:0] dev, input logic [4:0] sh);
		logic [ADDRESS_BITS-1:0] s;
		begin
			s = a >> sh;
			ctrl_of = dev | s[7:0];
		end
	endfunction

	always_comb begin
		lg = (cfg_q.page_size_log2 > 3'(MAX_PAGE_LOG2 > 7 ? 7 : MAX_PAGE_LOG2)
			&& MAX_PAGE_LOG2 < 7) ? 4'(MAX_PAGE_LOG2) : {1'b0, cfg_q.page_size_log2};
		page_sz = (PW+1)'(1) << lg;
		room = page_sz - ((PW+1)'(base_addr) & (page_sz - (PW+1)'(1)));
		seg_len = ({{(AW1 > PW+1 ? 1 : 1){1'b0}}, base_rem} < 17'(room)) ?
			PW'(base_rem) : PW'(room);
		ctrl_new = ctrl_of(base_addr, cfg_q.device_address, cfg_q.chip_select_shift);
		ctrl_cur = ctrl_of(cur_q, cfg_q.device_address, cfg_q.chip_select_shift);
		range_sum = AW1'(address) + AW1'(length);
		range_bad = ({{(AW1 > 19 ? AW1 : 19){1'b0}}} | range_sum) >
			({{(AW1 > 19 ? AW1 : 19){1'b0}}} | cfg_q.capacity_bytes);
	end

	always_comb begin
		base_addr = cur_q;
		base_rem = rem_q;
		if (phase_q == PH_IDLE) begin
			base_addr = address;
			base_rem = length;
		end
	end

	// Step logic: one input item in, a burst of beats out.
	always_comb begin
		logic open_seg, open_rd, recv;
		logic [ADDRESS_BITS-1:0] adr16;
		phase_d = phase_q;
		cur_d = cur_q;
		rem_d = rem_q;
		pleft_d = pleft_q;
		poll_d = poll_q;
		cnt = 3'd0;
		open_seg = 1'b0;
		open_rd = 1'b0;
		recv = 1'b0;
		adr16 = base_addr >> 8;
		for (int i = 0; i < MAX_RESULTS; i++) res[i] = '0;
		if (in_valid) begin
			case (opcode)
				OP_BEGIN_WRITE, OP_BEGIN_READ: begin
					if (phase_q == PH_IDLE) begin
						if (range_bad) begin
							res[0] = '{CMD_STATUS, 8'd0, ST_ADDR_ERROR, 1'b0};
							cnt = 3'd1;
						end else if (length == 16'd0) begin
							res[0] = '{CMD_STATUS, 8'd0, ST_DONE, 1'b0};
							cnt = 3'd1;
						end else begin
							cur_d = address;
							rem_d = length;
							poll_d = 8'd0;
							open_seg = 1'b1;
							open_rd = (opcode == OP_BEGIN_READ);
						end
					end
				end
				OP_WRITE_DATA: begin
					if (phase_q == PH_WR_DATA) begin
						res[0] = '{CMD_SEND, data, ST_BUSY, 1'b0};
						cnt = 3'd1;
						cur_d = cur_q + 1'b1;
						if (rem_q != 0) rem_d = rem_q - 1'b1;
						if (pleft_q != 0) pleft_d = pleft_q - 1'b1;
						if (pleft_q <= PW'(1)) begin
							res[1] = '{CMD_STOP, 8'd0, ST_BUSY, 1'b0};
							cnt = 3'd2;
							phase_d = PH_WR_STOP;
						end
					end
				end
				default: begin
					case (phase_q)
						PH_WR_STOP: begin
							cnt = 3'd1;
							if (!bus_ok) begin
								res[0] = '{CMD_STATUS, 8'd0, ST_WR_ERROR, 1'b0};
								phase_d = PH_IDLE;
							end else begin
								poll_d = 8'd1;
								res[0] = '{CMD_POLL, cfg_q.device_address, ST_BUSY, 1'b0};
								phase_d = PH_WR_POLL;
							end
						end
						PH_WR_POLL: begin
							if (bus_ok) begin
								poll_d = 8'd0;
								if (rem_q == 0) begin
									res[0] = '{CMD_STATUS, 8'd0, ST_DONE, 1'b0};
									cnt = 3'd1;
									phase_d = PH_IDLE;
								end else begin
									open_seg = 1'b1;
								end
							end else if (poll_q >= cfg_q.poll_limit) begin
								res[0] = '{CMD_STATUS, 8'd0, ST_WR_ERROR, 1'b0};
								cnt = 3'd1;
								phase_d = PH_IDLE;
							end else begin
								poll_d = poll_q + 1'b1;
								res[0] = '{CMD_POLL, cfg_q.device_address, ST_BUSY, 1'b0};
								cnt = 3'd1;
							end
						end
						PH_RD_ADDR: begin
							if (!bus_ok) begin
								res[0] = '{CMD_STATUS, 8'd0, ST_RD_ERROR, 1'b0};
								cnt = 3'd1;
								phase_d = PH_IDLE;
							end else begin
								res[0] = '{CMD_START_READ, ctrl_cur, ST_BUSY, 1'b0};
								cnt = 3'd1;
								recv = 1'b1;
							end
						end
						PH_RD_DATA: recv = 1'b1;
						PH_RD_NEXT: begin
							open_seg = 1'b1;
							open_rd = 1'b1;
						end
						default: ;
					endcase
				end
			endcase
		end
		if (open_seg) begin
			pleft_d = seg_len;
			res[cnt] = '{CMD_START_WRITE, ctrl_new, ST_BUSY, 1'b0};
			cnt = cnt + 3'd1;
			if (cfg_q.two_address_bytes) begin
				res[cnt] = '{CMD_SEND, adr16[7:0], ST_BUSY, 1'b0};
				cnt = cnt + 3'd1;
			end
			res[cnt] = '{CMD_SEND, base_addr[7:0], ST_BUSY, 1'b0};
			cnt = cnt + 3'd1;
			if (open_rd) begin
				res[cnt] = '{CMD_STOP, 8'd0, ST_BUSY, 1'b0};
				cnt = cnt + 3'd1;
				phase_d = PH_RD_ADDR;
			end else begin
				phase_d = PH_WR_DATA;
			end
		end
		if (recv) begin
			cur_d = cur_q + 1'b1;
			if (rem_q != 0) rem_d = rem_q - 1'b1;
			if (pleft_q != 0) pleft_d = pleft_q - 1'b1;
			if (pleft_q <= PW'(1)) begin
				res[cnt] = '{CMD_RECV_NACK, 8'd0, ST_BUSY, 1'b0};
				cnt = cnt + 3'd1;
				if (rem_q <= 16'd1) begin
					res[cnt] = '{CMD_STOP, 8'd0, ST_DONE, 1'b0};
					phase_d = PH_IDLE;
				end else begin
					res[cnt] = '{CMD_STOP, 8'd0, ST_BUSY, 1'b0};
					phase_d = PH_RD_NEXT;
				end
				cnt = cnt + 3'd1;
			end else begin
				res[cnt] = '{CMD_RECV_ACK, 8'd0, ST_BUSY, 1'b0};
				cnt = cnt + 3'd1;
				phase_d = PH_RD_DATA;
			end
		end
		if (cnt != 3'd0) res[cnt - 3'd1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cur_q <= '0;
			rem_q <= '0;
			pleft_q <= '0;
			poll_q <= '0;
			burst_count_s1 <= '0;
		end else begin
			phase_q <= phase_d;
			cur_q <= cur_d;
			rem_q <= rem_d;
			pleft_q <= pleft_d;
			poll_q <= poll_d;
			burst_count_s1 <= cnt;
		end
	end

	always_ff @(posedge clk) begin
		burst_s1 <= res;
	end
endmodule
`default_nettype wire

/* rtl/i2cee_queue.sv */
// Result queue: takes a burst of up to five beats per cycle and hands them out
// one beat at a time, oldest first. Depends on i2cee_pkg.
`timescale 1ns / 1ps
`default_nettype none
module i2cee_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  i2cee_pkg::result_t      burst_s1 [i2cee_pkg::MAX_RESULTS],
	input  wire logic [2:0]         burst_count_s1,
	input  wire logic               pop,
	output logic                    empty,
	output logic                    full,
	output i2cee_pkg::result_t      head
);
	import i2cee_pkg::*;

	localparam int DEPTH = 16;

	result_t mem_q [DEPTH];
	logic [3:0] wr_q, rd_q;
	logic [4:0] used_q;
	logic do_pop;

	assign empty = (used_q == 5'd0);
	// Room must remain for the burst in flight plus a full new one.
	assign full = (used_q > 5'(DEPTH - 2 * MAX_RESULTS));
	assign do_pop = pop && !empty;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (3'(i) < burst_count_s1) mem_q[wr_q + 4'(i)] <= burst_s1[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			used_q <= '0;
		end else begin
			wr_q <= wr_q + 4'(burst_count_s1);
			rd_q <= rd_q + 4'(do_pop);
			used_q <= used_q + 5'(burst_count_s1) - 5'(do_pop);
		end
	end
endmodule
`default_nettype wire
